/* rtl/minimal_standard_lcg_bounded_assert.svh */
// ----------------------------------------------------------------------------
// minimal_standard_lcg_bounded_assert.svh
// Assertion macros shared by the bounded minimal standard generator.
// ----------------------------------------------------------------------------
`ifndef MINIMAL_STANDARD_LCG_BOUNDED_ASSERT_SVH
`define MINIMAL_STANDARD_LCG_BOUNDED_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCGB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lcgb_pkg.sv */
// ----------------------------------------------------------------------------
// lcgb_pkg
// Types and constants for the bounded minimal standard generator.
// ----------------------------------------------------------------------------
package lcgb_pkg;

  localparam int unsigned STATE_W   = 31;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MULT_W    = 15;
  localparam int unsigned PROD_W    = STATE_W + MULT_W;
  localparam int unsigned DIV_STEPS = STATE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MULT_W-1:0]  LCG_MULT    = 15'd16807;
  localparam logic [STATE_W-1:0] LCG_MOD     = 31'h7FFF_FFFF;
  localparam logic [STATE_W-1:0] LCG_RESTART = 31'd123459876;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_DIV,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic seed_load;
    logic draw_load;
    logic reduce;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

/* rtl/lcgb_ctrl.sv */
// ----------------------------------------------------------------------------
// lcgb_ctrl
// Sequencer: seed load, multiply, reduce, remainder steps, result hand-off.
// ----------------------------------------------------------------------------
module lcgb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          mode_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  lcgb_pkg::sts_t sts_i,
  output lcgb_pkg::cmd_t cmd_o
);

  lcgb_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lcgb_pkg::ST_IDLE: begin
        if (in_valid_i && mode_i) state_d = lcgb_pkg::ST_RED;
      end
      lcgb_pkg::ST_RED: state_d = lcgb_pkg::ST_DIV;
      lcgb_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = lcgb_pkg::ST_OUT;
      end
      lcgb_pkg::ST_OUT: begin
        if (out_free) state_d = lcgb_pkg::ST_IDLE;
      end
      default: state_d = lcgb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lcgb_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.seed_load = in_valid_i && !mode_i;
        cmd_o.draw_load = in_valid_i && mode_i;
      end
      lcgb_pkg::ST_RED: cmd_o.reduce   = 1'b1;
      lcgb_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      lcgb_pkg::ST_OUT: cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/lcgb_dpath.sv */
// ----------------------------------------------------------------------------
// lcgb_dpath
// Generator state, x16807 product, mod 2^31-1 fold, restoring remainder unit.
// ----------------------------------------------------------------------------
module lcgb_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lcgb_pkg::cmd_t                  cmd_i,
  output lcgb_pkg::sts_t                  sts_o,
  input  logic [lcgb_pkg::WORD_W-1:0]     seed_value_i,
  input  logic [lcgb_pkg::WORD_W-1:0]     range_limit_i,
  output logic [lcgb_pkg::STATE_W-1:0]    random_value_o
);

  localparam int unsigned SW = lcgb_pkg::STATE_W;
  localparam int unsigned WW = lcgb_pkg::WORD_W;
  localparam int unsigned PW = lcgb_pkg::PROD_W;
  localparam int unsigned CW = lcgb_pkg::DIV_CNT_W;

  logic [SW-1:0] gen_q, gen_d;
  logic [PW-1:0] prod_q;
  logic [WW-1:0] limit_q;
  logic [SW-1:0] dvd_q;
  logic [WW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] res_q;

  logic [SW-1:0] mul_src;
  logic [WW-1:0] seed_sum;
  logic [SW-1:0] seed_mod;
  logic [WW-1:0] fold_sum;
  logic [SW-1:0] fold_mod;
  logic [WW:0]   trial;
  logic          fits;

  // zero state restarts from the fixed constant
  assign mul_src = (gen_q == '0) ? lcgb_pkg::LCG_RESTART : gen_q;

  // 2^31 == 1 (mod 2^31-1): fold top bits down, one conditional subtract
  assign seed_sum = {1'b0, seed_value_i[SW-1:0]} + WW'(seed_value_i[WW-1]);
  assign seed_mod = (seed_sum >= {1'b0, lcgb_pkg::LCG_MOD})
                  ? SW'(seed_sum - {1'b0, lcgb_pkg::LCG_MOD}) : seed_sum[SW-1:0];

  assign fold_sum = {1'b0, prod_q[SW-1:0]} + WW'(prod_q[PW-1:SW]);
  assign fold_mod = (fold_sum >= {1'b0, lcgb_pkg::LCG_MOD})
                  ? SW'(fold_sum - {1'b0, lcgb_pkg::LCG_MOD}) : fold_sum[SW-1:0];

  // one restoring step; a zero divisor leaves the dividend as remainder
  assign trial = {rem_q, dvd_q[SW-1]};
  assign fits  = trial >= {1'b0, limit_q};
  assign rem_d = fits ? WW'(trial - {1'b0, limit_q}) : trial[WW-1:0];

  always_comb begin
    gen_d = gen_q;
    if (cmd_i.seed_load) gen_d = seed_mod;
    else if (cmd_i.reduce) gen_d = fold_mod;
  end

  assign sts_o.div_last = (cnt_q == CW'(lcgb_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      cnt_q <= '0;
    end else begin
      gen_q <= gen_d;
      if (cmd_i.reduce) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_load) begin
      prod_q  <= PW'(mul_src) * PW'(lcgb_pkg::LCG_MULT);
      limit_q <= range_limit_i;
    end
    if (cmd_i.reduce) begin
      dvd_q <= fold_mod;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) res_q <= rem_q[SW-1:0];
  end

  assign random_value_o = res_q;

endmodule

/* rtl/minimal_standard_lcg_bounded.sv */
// ----------------------------------------------------------------------------
// minimal_standard_lcg_bounded
// Minimal standard (x16807 mod 2^31-1) generator with a bounded draw.
// ----------------------------------------------------------------------------
// A seed word (mode_i = 0) loads the 31-bit state with seed_value_i mod
// 2^31-1 in the cycle it is taken and gives no result; the block is ready for
// the next word straight away. A draw word (mode_i = 1) replaces a zero state
// by 123459876, advances the state by x16807 mod 2^31-1 and returns the new
// state mod range_limit_i (a zero limit returns the state itself). A draw
// keeps the input side busy through the 31x15 product, the end-around fold,
// the radix-2 restoring remainder unit (one bit per cycle) and the pass of the
// remainder to the output register. The output register holds the result
// until taken, so the following word can be accepted while it waits; a
// further draw cannot finish until it is taken.
module minimal_standard_lcg_bounded (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [lcgb_pkg::WORD_W-1:0]  seed_value_i,
  input  logic [lcgb_pkg::WORD_W-1:0]  range_limit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lcgb_pkg::STATE_W-1:0] random_value_o
);

  lcgb_pkg::cmd_t cmd;
  lcgb_pkg::sts_t sts;

  // sequencer: owns handshakes and the result-valid flag
  lcgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic: state, product, fold, remainder and result register
  lcgb_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .seed_value_i   (seed_value_i),
    .range_limit_i  (range_limit_i),
    .random_value_o (random_value_o)
  );

  // taken words, split by mode, for the checks below
  logic draw_take;
  logic seed_take;

  assign draw_take = in_valid_i && !in_stall_o && mode_i;
  assign seed_take = in_valid_i && !in_stall_o && !mode_i;

`include "minimal_standard_lcg_bounded_assert.svh"

  // a taken draw word keeps the input side busy next cycle
  `LCGB_ASSERT_NEXT(a_draw_busy, clk_i, rst_ni, draw_take, in_stall_o, "draw left input free")

  // a seed word leaves the block ready
  `LCGB_ASSERT_NEXT(a_seed_ready, clk_i, rst_ni, seed_take, !in_stall_o, "seed left block busy")

  // a new result only appears at the end of a draw
  `LCGB_ASSERT_NOW(a_res_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "stray result")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bounded minimal standard generator against a predictor held in
// the bench. Seed and draw words go in through a valid/stall driver with
// random gaps; results come back through a monitor with random back-pressure.
// Each result is compared with the oldest predicted draw.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STATE_W = lcgb_pkg::STATE_W;
  localparam int unsigned WORD_W  = lcgb_pkg::WORD_W;

  // Mode codes carried on mode_i
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Generator constants, kept local so the check does not lean on the RTL
  localparam longint unsigned MULTIPLIER    = 64'd16807;
  localparam longint unsigned MODULUS       = 64'd2147483647;
  localparam logic [STATE_W-1:0] RESTART_ST = 31'd123459876;

  localparam int unsigned RANDOM_WORDS = 780;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic              mode;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] limit;
    int unsigned       gap_after;  // idle cycles after this word is taken
  } word_t;

  // DUT ports; every input known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                mode_i         = MODE_SEED;
  logic [WORD_W-1:0]   seed_value_i   = '0;
  logic [WORD_W-1:0]   range_limit_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [STATE_W-1:0]  random_value_o;

  minimal_standard_lcg_bounded dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .seed_value_i   (seed_value_i),
    .range_limit_i  (range_limit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  // Bench-side copy of the generator and the draws still owed by the DUT
  logic [STATE_W-1:0] gen_state = '0;
  logic [STATE_W-1:0] expected_draws[$];
  word_t              pending_words[$];

  int unsigned total_words     = 0;
  int unsigned words_taken     = 0;
  int unsigned seeds_taken     = 0;
  int unsigned draws_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One Park-Miller step: s * 16807 mod (2^31 - 1)
  function automatic logic [STATE_W-1:0] lcg_step(logic [STATE_W-1:0] s);
    longint unsigned prod;
    prod = 64'(s) * MULTIPLIER;
    return STATE_W'(prod % MODULUS);
  endfunction

  // Applies an accepted word to the bench state; a draw queues its result.
  function automatic void apply_word(logic mode, logic [WORD_W-1:0] seed,
                                     logic [WORD_W-1:0] limit);
    logic [STATE_W-1:0] draw;
    if (mode == MODE_SEED) begin
      // a seed of 0 or of the modulus leaves the state at zero
      gen_state = STATE_W'(64'(seed) % MODULUS);
      seeds_taken++;
    end else begin
      // zero state would lock the generator, so it restarts
      if (gen_state == '0) gen_state = RESTART_ST;
      gen_state = lcg_step(gen_state);
      // zero limit: remainder is the state itself (never driven here)
      if (limit == '0) draw = gen_state;
      else draw = STATE_W'(64'(gen_state) % 64'(limit));
      expected_draws.push_back(draw);
      draws_taken++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Input driver: presents queued words, holds them while stalled and then
  // idles for the gap that each word carries.
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      mode_i        <= MODE_SEED;
      seed_value_i  <= '0;
      range_limit_i <= '0;
      gap_left      <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_word(mode_i, seed_value_i, range_limit_i);
        words_taken++;
      end
      // the slot is free when nothing is shown or the shown word was taken
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_valid_i    <= 1'b1;
          mode_i        <= w.mode;
          seed_value_i  <= w.seed;
          range_limit_i <= w.limit;
          gap_left      <= w.gap_after;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each taken result and draws how long to stall the
  // next one. The stall counts down only while a result is on offer, so it
  // always bites; every third run of 64 results is taken without stalls.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    logic [STATE_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_draws.size() == 0) begin
          $error("random_value: expected none, actual %0d", random_value_o);
          error_count++;
        end else begin
          want = expected_draws.pop_front();
          if (random_value_o !== want) begin
            $error("random_value: expected %0d, actual %0d", want, random_value_o);
            error_count++;
          end
        end
        results_checked++;
        n = ((results_checked / 64) % 3 == 2) ? 0 : $urandom_range(0, 5);
        stall_left  <= n;
        out_stall_i <= (n != 0);
      end else if (out_valid_o && out_stall_i) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_word(logic mode, logic [WORD_W-1:0] seed,
                          logic [WORD_W-1:0] limit, int unsigned gap);
    word_t w;
    w.mode      = mode;
    w.seed      = seed;
    w.limit     = limit;
    w.gap_after = gap;
    pending_words.push_back(w);
    total_words++;
  endtask

  function automatic logic [WORD_W-1:0] pick_limit();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(1, 16);
      1:       v = $urandom_range(1, 65536);
      2:       v = $urandom;
      default: v = $urandom_range(32'h7FFF_FFF0, 32'hFFFF_FFFF);
    endcase
    return (v == '0) ? 32'd1 : v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned gap;

    // Directed words
    // draw straight out of reset: zero state restarts
    add_word(MODE_DRAW, 32'h0000_0000, 32'hFFFF_FFFF, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'hFFFF_FFFF, 32'h7FFF_FFFF, $urandom_range(0, 5));
    // seed 0: state stays zero, next draw restarts; limit 1 gives 0
    add_word(MODE_SEED, 32'h0000_0000, 32'hFFFF_FFFF, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'hFFFF_FFFF, 32'h0000_0001, $urandom_range(0, 5));
    // seed equal to the modulus also folds to zero
    add_word(MODE_SEED, 32'h7FFF_FFFF, 32'h0000_0000, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'h0000_0000, 32'h8000_0000, $urandom_range(0, 5));
    // all-ones seed folds to 1
    add_word(MODE_SEED, 32'hFFFF_FFFF, 32'h1234_5678, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'h5555_5555, 32'h0000_0002, $urandom_range(0, 5));
    // 2^31 folds to 1 too
    add_word(MODE_SEED, 32'h8000_0000, 32'hAAAA_AAAA, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'hAAAA_AAAA, 32'hFFFF_FFFF, $urandom_range(0, 5));
    // largest reachable state, then large and small limits
    add_word(MODE_SEED, 32'h7FFF_FFFE, 32'hFFFF_FFFF, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'h0000_0000, 32'h7FFF_FFFE, $urandom_range(0, 5));
    add_word(MODE_DRAW, 32'h0000_0000, 32'h0000_0003, $urandom_range(0, 5));
    add_word(MODE_SEED, 32'h0000_0001, 32'h0000_0000, 0);
    // back-to-back seeds: only the last one counts
    add_word(MODE_SEED, 32'hDEAD_BEEF, 32'h0000_0000, 0);
    add_word(MODE_SEED, 32'h0000_0001, 32'hFFFF_FFFF, 0);
    add_word(MODE_DRAW, 32'hFFFF_FFFF, 32'h0000_0007, 0);
    add_word(MODE_DRAW, 32'h0000_0000, 32'h0001_0000, 0);
    add_word(MODE_DRAW, 32'h0000_0000, 32'h8000_0001, 0);
    add_word(MODE_DRAW, 32'h0000_0000, 32'hFFFF_FFFE, $urandom_range(0, 5));

    // Random words: mostly draws, seeds now and then; unused fields random.
    // Every third run of 64 words goes with no input gaps.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      gap = ((i / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) add_word(MODE_SEED, pick_seed(), $urandom, gap);
      else add_word(MODE_DRAW, $urandom, pick_limit(), gap);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all words in, then all results back, then a quiet spell
    while (words_taken < total_words) @(negedge clk_i);
    while (expected_draws.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d words: %0d seeds and %0d draws.",
             words_taken, seeds_taken, draws_taken);
    $display("%0d results checked, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lcgb_pkg.sv
rtl/lcgb_ctrl.sv
rtl/lcgb_dpath.sv
rtl/minimal_standard_lcg_bounded.sv
verif/testbench.sv
